/* hdl/assert_macros.svh */
// Assertion helpers shared by the handle pool RTL.
// Properties are sampled on clk and disabled while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every clock edge.
`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, pre, post, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) else $error(msg);

`endif

/* hdl/sghp_pkg.sv */
// Types and constants of the scoped generation handle pool.
// Used by every module of the block; depends on nothing.
package sghp_pkg;

	localparam int INDEX_W         = 8;
	localparam int GEN_W           = 16;
	localparam int POOL_SIZE_DEF   = 256;
	localparam int STACK_DEPTH_DEF = 64;

	typedef enum logic [1:0] {
		KIND_BEGIN = 2'd0,
		KIND_END   = 2'd1,
		KIND_CHECK = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_EXHAUSTED = 2'd1,
		ST_OVERFLOW  = 2'd2,
		ST_EMPTY     = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		STK_HOLD    = 2'd0,
		STK_PUSH    = 2'd1,
		STK_POP     = 2'd2,
		STK_REPLACE = 2'd3
	} stk_op_t;

	typedef struct packed {
		kind_t              kind;
		logic [INDEX_W-1:0] query_index;
		logic [GEN_W-1:0]   query_generation;
	} req_t;

	typedef struct packed {
		status_t            status;
		logic [INDEX_W-1:0] handle_index;
		logic [GEN_W-1:0]   handle_generation;
		logic               is_valid;
		logic [INDEX_W-1:0] current_index;
		logic [GEN_W-1:0]   current_generation;
	} rsp_t;

	// Stack entry; index in the low bits.
	typedef struct packed {
		logic [GEN_W-1:0]   gen;
		logic [INDEX_W-1:0] idx;
	} handle_t;

	// Slot table updates from one request.
	typedef struct packed {
		logic               set_en;
		logic [INDEX_W-1:0] set_idx;
		logic [GEN_W-1:0]   set_gen;
		logic               clr_en;
		logic [INDEX_W-1:0] clr_idx;
	} slot_upd_t;

endpackage

/* hdl/sghp_stack.sv */
// LIFO stack: top two entries in registers, the rest in a memory with registered read.
// Optional reset contents: position p holds p + 1. Depends on sghp_pkg.
module sghp_stack import sghp_pkg::*; #(
	parameter int DEPTH      = STACK_DEPTH_DEF,
	parameter int WIDTH      = $bits(handle_t),
	parameter int INIT_COUNT = 0
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  stk_op_t                      op,
	input  logic [WIDTH-1:0]             din,
	output logic [$clog2(DEPTH+1)-1:0]   count,
	output logic [WIDTH-1:0]             top,
	output logic [WIDTH-1:0]             second
);

	localparam int CW       = $clog2(DEPTH + 1);
	localparam int AW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int INIT_LOW = (INIT_COUNT > 2) ? INIT_COUNT - 2 : 0;
	localparam int INIT_C1  = (INIT_COUNT > 1) ? INIT_COUNT - 1 : 0;

	logic [WIDTH-1:0] mem [DEPTH];
	logic [CW-1:0]    cnt_q;
	logic [CW-1:0]    low_q;      // memory positions below this still hold reset contents
	logic [WIDTH-1:0] c0_q;
	logic [WIDTH-1:0] c1_q;
	logic             c1_rd_q;    // second entry sits in the read register
	logic [WIDTH-1:0] rd_q;
	logic [CW-1:0]    rd_pos_q;
	logic             rd_fresh_q;
	logic             deep;
	logic             spill;
	logic [CW-1:0]    rd_pos;
	logic [CW-1:0]    region_pop;

	function automatic logic [WIDTH-1:0] init_entry(input logic [CW-1:0] pos);
		return WIDTH'(pos) + WIDTH'(1);
	endfunction

	assign deep       = int'(cnt_q) >= 3;
	assign spill      = int'(cnt_q) >= 2;
	assign rd_pos     = cnt_q - CW'(3);
	assign region_pop = deep ? rd_pos : '0;

	assign second = c1_rd_q ? (rd_fresh_q ? rd_q : init_entry(rd_pos_q)) : c1_q;
	assign top    = c0_q;
	assign count  = cnt_q;

	always_ff @(posedge clk) begin
		if (op == STK_PUSH && spill) begin
			mem[AW'(cnt_q - CW'(2))] <= second;
		end
		if (op == STK_POP && deep) begin
			rd_q       <= mem[AW'(rd_pos)];
			rd_pos_q   <= rd_pos;
			rd_fresh_q <= rd_pos >= low_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= CW'(INIT_COUNT);
			low_q   <= CW'(INIT_LOW);
			c0_q    <= WIDTH'(INIT_COUNT);
			c1_q    <= WIDTH'(INIT_C1);
			c1_rd_q <= 1'b0;
		end else begin
			unique case (op)
				STK_PUSH: begin
					cnt_q   <= cnt_q + CW'(1);
					c0_q    <= din;
					c1_q    <= c0_q;
					c1_rd_q <= 1'b0;
				end
				STK_POP: begin
					cnt_q   <= cnt_q - CW'(1);
					c0_q    <= second;
					c1_rd_q <= 1'b1;
					if (region_pop < low_q) begin
						low_q <= region_pop;
					end
				end
				STK_REPLACE: begin
					c0_q <= din;
				end
				STK_HOLD: begin
				end
			endcase
		end
	end

endmodule

/* hdl/sghp_slot_table.sv */
// Per-slot alive flags and generation memory, plus the handle check.
// Generation and alive reads are issued when a request is registered. Depends on sghp_pkg.
module sghp_slot_table import sghp_pkg::*; #(
	parameter int POOL_SIZE = POOL_SIZE_DEF
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               rd_en,
	input  logic [INDEX_W-1:0] rd_idx,
	input  slot_upd_t          upd,
	input  logic [INDEX_W-1:0] chk_idx,
	input  logic [GEN_W-1:0]   chk_gen,
	output logic               hit
);

	localparam int IW = $clog2(POOL_SIZE);

	logic [POOL_SIZE-1:0] alive_q;
	logic [GEN_W-1:0]     gen_mem [POOL_SIZE];
	logic [GEN_W-1:0]     rd_q;
	logic [GEN_W-1:0]     fwd_gen_q;
	logic                 fwd_q;
	logic                 alive_rd_q;
	logic [GEN_W-1:0]     slot_gen;

	function automatic logic in_pool(input logic [INDEX_W-1:0] idx);
		return (idx != '0) && ({1'b0, idx} < (INDEX_W+1)'(POOL_SIZE));
	endfunction

	function automatic logic [IW-1:0] slot_sel(input logic [INDEX_W-1:0] idx);
		return in_pool(idx) ? idx[IW-1:0] : '0;
	endfunction

	always_ff @(posedge clk) begin
		if (upd.set_en) begin
			gen_mem[slot_sel(upd.set_idx)] <= upd.set_gen;
		end
		if (rd_en) begin
			rd_q       <= gen_mem[slot_sel(rd_idx)];
			fwd_q      <= upd.set_en && (upd.set_idx == rd_idx);
			fwd_gen_q  <= upd.set_gen;
			alive_rd_q <= (upd.set_en && (upd.set_idx == rd_idx)) ||
				(alive_q[slot_sel(rd_idx)] && !(upd.clr_en && (upd.clr_idx == rd_idx)));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			alive_q <= '0;
		end else begin
			if (upd.set_en) begin
				alive_q[slot_sel(upd.set_idx)] <= 1'b1;
			end
			if (upd.clr_en) begin
				alive_q[slot_sel(upd.clr_idx)] <= 1'b0;
			end
		end
	end

	assign slot_gen = fwd_q ? fwd_gen_q : rd_q;
	assign hit      = in_pool(chk_idx) && alive_rd_q && (slot_gen == chk_gen);

endmodule

/* hdl/scoped_generation_handle_pool_unit.sv */
// Top level of the scoped generation handle pool: request register, step logic,
// response register. Uses sghp_pkg, sghp_stack, sghp_slot_table and assert_macros.svh.
//
// One request is taken per clock unless req_stall is high, which happens while a request
// waits in the request register behind a stalled response; each response is registered.
// Both the free list and the scope stack keep their top two entries in registers over a
// memory with registered read, which is what lets a pop be followed by another pop in
// the next cycle. No clearing pass runs after reset; the block takes requests right away.
// POOL_SIZE ranges 2 to 256 (the index field is 8 bits), STACK_DEPTH from 1 up.
`include "assert_macros.svh"

module scoped_generation_handle_pool_unit import sghp_pkg::*; #(
	parameter int POOL_SIZE   = POOL_SIZE_DEF,
	parameter int STACK_DEPTH = STACK_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_stall,
	input  req_t req_data,
	output logic rsp_valid,
	input  logic rsp_stall,
	output rsp_t rsp_data
);

	localparam int FCW = $clog2(POOL_SIZE + 1);
	localparam int SCW = $clog2(STACK_DEPTH + 1);
	localparam int HW  = $bits(handle_t);

	req_t             req_s1;
	logic             valid_s1;
	rsp_t             rsp_q;
	logic             rsp_valid_q;
	logic             advance;
	logic             take;

	stk_op_t          free_op;
	stk_op_t          scope_op;
	handle_t          free_din;
	handle_t          scope_din;
	logic [FCW-1:0]   free_cnt;
	logic [SCW-1:0]   scope_cnt;
	logic [HW-1:0]    free_top_w;
	logic [HW-1:0]    free_sec_w;
	logic [HW-1:0]    scope_top_w;
	logic [HW-1:0]    scope_sec_w;
	handle_t          free_top;
	handle_t          free_sec;
	handle_t          scope_top;
	handle_t          scope_sec;
	handle_t          cur;
	handle_t          cur_after;
	logic [GEN_W-1:0] new_gen;
	slot_upd_t        upd;
	logic             hit;
	rsp_t             rsp_next;
	logic             slots_balanced;
	logic             begin_ok;
	logic             rsp_cur_match;

	assign advance   = valid_s1 && (!rsp_valid_q || !rsp_stall);
	assign req_stall = valid_s1 && !advance;
	assign take      = req_valid && !req_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!req_stall) begin
			valid_s1 <= req_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			req_s1 <= req_data;
		end
	end

	sghp_stack #(
		.DEPTH      (POOL_SIZE),
		.WIDTH      (HW),
		.INIT_COUNT (POOL_SIZE - 1)
	) u_spare_stack (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (free_op),
		.din    (free_din),
		.count  (free_cnt),
		.top    (free_top_w),
		.second (free_sec_w)
	);

	sghp_stack #(
		.DEPTH      (STACK_DEPTH),
		.WIDTH      (HW),
		.INIT_COUNT (0)
	) u_scope_stack (
		.clk    (clk),
		.arst_n (arst_n),
		.op     (scope_op),
		.din    (scope_din),
		.count  (scope_cnt),
		.top    (scope_top_w),
		.second (scope_sec_w)
	);

	sghp_slot_table #(
		.POOL_SIZE (POOL_SIZE)
	) u_slot_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (take),
		.rd_idx  (req_data.query_index),
		.upd     (upd),
		.chk_idx (req_s1.query_index),
		.chk_gen (req_s1.query_generation),
		.hit     (hit)
	);

	assign free_top  = handle_t'(free_top_w);
	assign free_sec  = handle_t'(free_sec_w);
	assign scope_top = handle_t'(scope_top_w);
	assign scope_sec = handle_t'(scope_sec_w);
	assign new_gen   = free_top.gen + GEN_W'(1);
	assign cur       = (scope_cnt != '0) ? scope_top : '0;

	always_comb begin
		free_op   = STK_HOLD;
		scope_op  = STK_HOLD;
		free_din  = free_top;
		scope_din = '{gen: new_gen, idx: free_top.idx};
		upd       = '0;
		cur_after = cur;
		rsp_next  = '0;
		if (advance) begin
			unique case (req_s1.kind)
				KIND_BEGIN: begin
					if (free_cnt == '0) begin
						rsp_next.status = ST_EXHAUSTED;
					end else if (scope_cnt == SCW'(STACK_DEPTH)) begin
						// slot goes straight back with its generation advanced
						free_op         = STK_REPLACE;
						free_din        = '{gen: new_gen, idx: free_top.idx};
						rsp_next.status = ST_OVERFLOW;
					end else begin
						free_op                    = STK_POP;
						scope_op                   = STK_PUSH;
						upd.set_en                 = 1'b1;
						upd.set_idx                = free_top.idx;
						upd.set_gen                = new_gen;
						rsp_next.handle_index      = free_top.idx;
						rsp_next.handle_generation = new_gen;
						cur_after                  = '{gen: new_gen, idx: free_top.idx};
					end
				end
				KIND_END: begin
					if (scope_cnt == '0) begin
						rsp_next.status = ST_EMPTY;
					end else begin
						scope_op    = STK_POP;
						free_op     = STK_PUSH;
						free_din    = scope_top;
						upd.clr_en  = 1'b1;
						upd.clr_idx = scope_top.idx;
						cur_after   = (scope_cnt > SCW'(1)) ? scope_sec : '0;
					end
				end
				KIND_CHECK: begin
					rsp_next.is_valid = hit;
				end
				default: begin
				end
			endcase
		end
		rsp_next.current_index      = cur_after.idx;
		rsp_next.current_generation = cur_after.gen;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (advance) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			rsp_q <= rsp_next;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp_data  = rsp_q;

	// every slot but null is either free or on the scope stack
	assign slots_balanced = (int'(free_cnt) + int'(scope_cnt)) == (POOL_SIZE - 1);
	assign begin_ok       = advance && (req_s1.kind == KIND_BEGIN) && (rsp_next.status == ST_OK);
	assign rsp_cur_match  = (rsp_data.handle_index != '0) &&
		(rsp_data.handle_index == rsp_data.current_index) &&
		(rsp_data.handle_generation == rsp_data.current_generation);

	`ASSERT_ALWAYS(a_slot_conservation, slots_balanced, "slot count mismatch")

	`ASSERT_ALWAYS(a_null_current_when_empty, (scope_cnt != '0) || (cur == '0), "stray current")

	`ASSERT_ALWAYS(a_free_distinct, (free_cnt < FCW'(2)) || (free_sec.idx != free_top.idx), "dup slot")

	`ASSERT_NEXT(a_begin_becomes_current, begin_ok, rsp_cur_match, "new handle is not current")

endmodule

/* tb/sv/tb_top.sv */
// Self-checking bench for scoped_generation_handle_pool_unit: directed table, then random
// begin/end/check traffic against an in-bench model of the pool, free list and scope stack.
// Depends on sghp_pkg and the RTL of the block only.
module tb_top import sghp_pkg::*;;

	timeunit 1ns;
	timeprecision 1ps;

	localparam int POOL_SIZE   = POOL_SIZE_DEF;
	localparam int STACK_DEPTH = STACK_DEPTH_DEF;
	localparam int RAND_ITEMS  = 700;
	localparam int HOLD_CYCLES = 80;
	localparam int DRAIN_WAIT  = 10;
	localparam int CYCLE_LIMIT = 200000;
	localparam kind_t KIND_NOP = kind_t'(2'b11);

	typedef struct {
		req_t req;
		bit   typed;
		rsp_t rsp;
	} dir_row_t;

	logic clk;
	logic arst_n;
	logic req_valid;
	logic req_stall;
	req_t req_data;
	logic rsp_valid;
	logic rsp_stall;
	rsp_t rsp_data;

	// pool model state
	logic [GEN_W-1:0] slot_gen [POOL_SIZE];
	bit               slot_live [POOL_SIZE];
	int unsigned      spare_slots [POOL_SIZE];
	int unsigned      free_cnt;
	int unsigned      scope_idx [STACK_DEPTH];
	logic [GEN_W-1:0] scope_gen [STACK_DEPTH];
	int unsigned      scope_top;
	int unsigned      cur_idx;
	logic [GEN_W-1:0] cur_gen;

	rsp_t        pending_rsp [$];
	dir_row_t    dir_rows [$];
	int unsigned errors;
	int unsigned cycles;
	bit          quiet;
	bit          hold_off_req;

	scoped_generation_handle_pool_unit #(
		.POOL_SIZE  (POOL_SIZE),
		.STACK_DEPTH(STACK_DEPTH)
	) DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.req_valid(req_valid),
		.req_stall(req_stall),
		.req_data (req_data),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp_data (rsp_data)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	task automatic report_mismatch(input string what, input longint got, input longint want);
		$display("mismatch %s: got %0d expected %0d", what, got, want);
		errors++;
	endtask

	task automatic check_rsp(input rsp_t got, input rsp_t want);
		if (got.status !== want.status)
			report_mismatch("status", got.status, want.status);
		if (got.handle_index !== want.handle_index)
			report_mismatch("handle_index", got.handle_index, want.handle_index);
		if (got.handle_generation !== want.handle_generation)
			report_mismatch("handle_generation", got.handle_generation, want.handle_generation);
		if (got.is_valid !== want.is_valid)
			report_mismatch("is_valid", got.is_valid, want.is_valid);
		if (got.current_index !== want.current_index)
			report_mismatch("current_index", got.current_index, want.current_index);
		if (got.current_generation !== want.current_generation)
			report_mismatch("current_generation", got.current_generation,
				want.current_generation);
	endtask

	function automatic void pool_reset();
		for (int i = 0; i < POOL_SIZE; i++) begin
			slot_gen[i]    = '0;
			slot_live[i]   = 1'b0;
			spare_slots[i] = i + 1;
		end
		free_cnt  = POOL_SIZE - 1;
		scope_top = 0;
		cur_idx   = 0;
		cur_gen   = '0;
	endfunction

	function automatic void release_slot(input int unsigned idx, input logic [GEN_W-1:0] gen);
		if (idx == 0 || idx >= POOL_SIZE)
			return;
		if (slot_gen[idx] != gen || !slot_live[idx])
			return;
		slot_live[idx] = 1'b0;
		if (free_cnt < POOL_SIZE) begin
			spare_slots[free_cnt] = idx;
			free_cnt++;
		end
	endfunction

	function automatic rsp_t pool_step(input req_t r);
		rsp_t             o;
		int unsigned      idx;
		logic [GEN_W-1:0] gen;
		o = '0;
		o.status = ST_OK;
		case (r.kind)
			KIND_BEGIN: begin
				if (free_cnt == 0) begin
					o.status = ST_EXHAUSTED;
				end else begin
					free_cnt--;
					idx = spare_slots[free_cnt];
					gen = slot_gen[idx] + 1'b1;
					slot_gen[idx]  = gen;
					slot_live[idx] = 1'b1;
					if (scope_top >= STACK_DEPTH) begin
						release_slot(idx, gen);
						o.status = ST_OVERFLOW;
					end else begin
						scope_idx[scope_top] = idx;
						scope_gen[scope_top] = gen;
						scope_top++;
						cur_idx = idx;
						cur_gen = gen;
						o.handle_index      = INDEX_W'(idx);
						o.handle_generation = gen;
					end
				end
			end
			KIND_END: begin
				if (scope_top == 0) begin
					o.status = ST_EMPTY;
				end else begin
					scope_top--;
					release_slot(scope_idx[scope_top], scope_gen[scope_top]);
					if (scope_top == 0) begin
						cur_idx = 0;
						cur_gen = '0;
					end else begin
						cur_idx = scope_idx[scope_top - 1];
						cur_gen = scope_gen[scope_top - 1];
					end
				end
			end
			KIND_CHECK: begin
				if (r.query_index != 0 && int'(r.query_index) < POOL_SIZE)
					o.is_valid = slot_live[r.query_index] &&
						slot_gen[r.query_index] == r.query_generation;
			end
			default: ;
		endcase
		o.current_index      = INDEX_W'(cur_idx);
		o.current_generation = cur_gen;
		return o;
	endfunction

	// phases of 120 requests: nest deep (reaches overflow), mixed, unwind
	function automatic req_t next_request(input int unsigned n);
		req_t        r;
		int unsigned roll;
		int unsigned b_w;
		int unsigned e_w;
		int unsigned k;
		case ((n / 120) % 3)
			0: begin
				b_w = 70;
				e_w = 12;
			end
			1: begin
				b_w = 40;
				e_w = 35;
			end
			default: begin
				b_w = 15;
				e_w = 65;
			end
		endcase
		r.query_index      = INDEX_W'($urandom_range(255));
		r.query_generation = GEN_W'($urandom_range(65535));
		roll = $urandom_range(99);
		if (roll < b_w) begin
			r.kind = KIND_BEGIN;
		end else if (roll < b_w + e_w) begin
			r.kind = KIND_END;
		end else if (roll < 97) begin
			r.kind = KIND_CHECK;
			case ($urandom_range(3))
				1: if (scope_top > 0) begin
					k = $urandom_range(scope_top - 1);
					r.query_index      = INDEX_W'(scope_idx[k]);
					r.query_generation = scope_gen[k];
				end
				2: r.query_generation = slot_gen[r.query_index];
				3: if (scope_top > 0) begin
					k = $urandom_range(scope_top - 1);
					r.query_index      = INDEX_W'(scope_idx[k]);
					r.query_generation = scope_gen[k] ^ (GEN_W'(1) << $urandom_range(GEN_W - 1));
				end
				default: ;
			endcase
		end else begin
			r.kind = KIND_NOP;
		end
		return r;
	endfunction

	task automatic offer(input req_t r, input bit typed, input rsp_t typed_rsp);
		rsp_t predicted;
		while (!quiet && $urandom_range(99) < 23) begin
			req_valid <= 1'b0;
			@(posedge clk);
		end
		req_valid <= 1'b1;
		req_data  <= r;
		@(posedge clk);
		while (req_stall)
			@(posedge clk);
		predicted = pool_step(r);
		pending_rsp.push_back(typed ? typed_rsp : predicted);
	endtask

	task automatic add_row(input kind_t kind, input int unsigned qidx, input int unsigned qgen,
		input bit typed, input status_t st, input int unsigned hidx, input int unsigned hgen,
		input bit ok, input int unsigned cidx, input int unsigned cgen);
		dir_row_t row;
		row.req.kind              = kind;
		row.req.query_index       = INDEX_W'(qidx);
		row.req.query_generation  = GEN_W'(qgen);
		row.typed                 = typed;
		row.rsp.status            = st;
		row.rsp.handle_index      = INDEX_W'(hidx);
		row.rsp.handle_generation = GEN_W'(hgen);
		row.rsp.is_valid          = ok;
		row.rsp.current_index     = INDEX_W'(cidx);
		row.rsp.current_generation = GEN_W'(cgen);
		dir_rows.push_back(row);
	endtask

	// response side: check, then pick next stall
	initial begin
		int unsigned hold_cnt;
		rsp_t        want;
		hold_cnt = 0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_valid && !rsp_stall) begin
				if (pending_rsp.size() == 0) begin
					report_mismatch("request response with none expected",
						longint'(rsp_data.status), 0);
				end else begin
					want = pending_rsp.pop_front();
					check_rsp(rsp_data, want);
				end
			end
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				hold_cnt = HOLD_CYCLES;
			end
			if (hold_cnt > 0) begin
				hold_cnt--;
				rsp_stall <= 1'b1;
			end else if (quiet) begin
				rsp_stall <= 1'b0;
			end else begin
				rsp_stall <= ($urandom_range(99) < 23);
			end
		end
	end

	initial begin
		rsp_t none;
		none = '0;
		errors = 0;
		cycles = 0;
		quiet = 1'b0;
		hold_off_req = 1'b0;
		arst_n = 1'b0;
		req_valid = 1'b0;
		req_data = '0;
		rsp_stall = 1'b0;
		pool_reset();

		add_row(KIND_CHECK, 0, 0, 1, ST_OK, 0, 0, 0, 0, 0);
		add_row(KIND_END, 0, 0, 1, ST_EMPTY, 0, 0, 0, 0, 0);
		add_row(KIND_BEGIN, 255, 65535, 1, ST_OK, 255, 1, 0, 255, 1);
		add_row(KIND_CHECK, 255, 1, 1, ST_OK, 0, 0, 1, 255, 1);
		add_row(KIND_CHECK, 255, 0, 1, ST_OK, 0, 0, 0, 255, 1);
		add_row(KIND_CHECK, 255, 65535, 1, ST_OK, 0, 0, 0, 255, 1);
		add_row(KIND_CHECK, 0, 65535, 1, ST_OK, 0, 0, 0, 255, 1);
		add_row(KIND_NOP, 255, 65535, 1, ST_OK, 0, 0, 0, 255, 1);
		add_row(KIND_BEGIN, 0, 0, 1, ST_OK, 254, 1, 0, 254, 1);
		add_row(KIND_CHECK, 254, 1, 1, ST_OK, 0, 0, 1, 254, 1);
		add_row(KIND_END, 170, 43690, 1, ST_OK, 0, 0, 0, 255, 1);
		add_row(KIND_CHECK, 254, 1, 1, ST_OK, 0, 0, 0, 255, 1);
		add_row(KIND_BEGIN, 85, 21845, 0, ST_OK, 0, 0, 0, 0, 0);
		add_row(KIND_CHECK, 254, 2, 0, ST_OK, 0, 0, 0, 0, 0);
		add_row(KIND_END, 0, 0, 0, ST_OK, 0, 0, 0, 0, 0);
		add_row(KIND_END, 0, 0, 0, ST_OK, 0, 0, 0, 0, 0);
		add_row(KIND_END, 0, 0, 1, ST_EMPTY, 0, 0, 0, 0, 0);
		add_row(KIND_CHECK, 170, 43690, 0, ST_OK, 0, 0, 0, 0, 0);
		add_row(KIND_CHECK, 85, 21845, 0, ST_OK, 0, 0, 0, 0, 0);
		add_row(KIND_NOP, 0, 0, 0, ST_OK, 0, 0, 0, 0, 0);

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			offer(dir_rows[i].req, dir_rows[i].typed, dir_rows[i].rsp);

		for (int unsigned n = 0; n < RAND_ITEMS; n++) begin
			if (n == 250)
				hold_off_req = 1'b1;
			quiet = (n >= 430 && n < 530);
			offer(next_request(n), 1'b0, none);
		end
		req_valid <= 1'b0;

		while (pending_rsp.size() != 0)
			@(posedge clk);
		repeat (DRAIN_WAIT) @(posedge clk);
		if (errors == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
